/* rtl/core/l3d_pkg.sv */
// Shared constants, codes and types of the 3D line distance tester.
package l3d_pkg;

   // Default coordinate width and the fixed binary point position.
   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS       = 16;
   localparam int TOL_RESET       = 66;

   // Multiplier slicing: operand chunk width and pipeline latency.
   localparam int MUL_CHUNK = 32;
   localparam int MUL_LAT   = 5;

   // Result status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_REF_DEGEN = 2'd1;
   localparam logic [1:0] ST_QRY_DEGEN = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] REG_A_X = 3'd0;
   localparam logic [2:0] REG_A_Y = 3'd1;
   localparam logic [2:0] REG_A_Z = 3'd2;
   localparam logic [2:0] REG_B_X = 3'd3;
   localparam logic [2:0] REG_B_Y = 3'd4;
   localparam logic [2:0] REG_B_Z = 3'd5;
   localparam logic [2:0] REG_TOL = 3'd6;

   // Item flags in the front half of the pipeline.
   typedef struct packed {
      logic vld;
      logic line;
      logic d_zero;
      logic e_zero;
   } fmeta_type;

   // Item flags once the query has been classified.
   typedef struct packed {
      logic       vld;
      logic       par;
      logic [1:0] status;
   } bmeta_type;

   // Result flags, packed as they leave on the user sideband (in_tol at bit 0).
   typedef struct packed {
      logic [1:0] status;
      logic       par;
      logic       in_tol;
   } rflag_type;

endpackage

/* rtl/core/l3d_mul.sv */
// Pipelined signed multiplier built from 32-bit chunk products.
module l3d_mul import l3d_pkg::*; #(
   parameter int A_WIDTH = 33,
   parameter int B_WIDTH = 33
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [A_WIDTH-1:0]         a,
   input  logic signed [B_WIDTH-1:0]         b,
   output logic signed [A_WIDTH+B_WIDTH-1:0] p
);

   localparam int NA  = (A_WIDTH + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int NB  = (B_WIDTH + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int AP  = NA * MUL_CHUNK;
   localparam int BP  = NB * MUL_CHUNK;
   localparam int PW  = A_WIDTH + B_WIDTH;
   localparam int SPW = AP + BP;
   localparam int RWD = MUL_CHUNK + BP;

   logic [A_WIDTH-1:0]       a_abs;
   logic [B_WIDTH-1:0]       b_abs;
   logic [AP-1:0]            a_mag_ff;
   logic [BP-1:0]            b_mag_ff;
   logic                     neg_ff [4];
   logic [2*MUL_CHUNK-1:0]   pp_in [NA][NB];
   logic [2*MUL_CHUNK-1:0]   pp_ff [NA][NB];
   logic [RWD-1:0]           row_in [NA];
   logic [RWD-1:0]           row_ff [NA];
   logic [SPW-1:0]           mag_in;
   logic [SPW-1:0]           mag_ff;
   logic [PW-1:0]            mag_pw;
   logic signed [PW-1:0]     p_ff;

   // Magnitudes of both operands; the product sign travels alongside.
   assign a_abs = a[A_WIDTH-1] ? (~a + 1'b1) : a;
   assign b_abs = b[B_WIDTH-1] ? (~b + 1'b1) : b;

   always_ff @(posedge clock) begin
      if (en) begin
         a_mag_ff  <= AP'(a_abs);
         b_mag_ff  <= BP'(b_abs);
         neg_ff[0] <= a[A_WIDTH-1] ^ b[B_WIDTH-1];
         for (int k = 1; k < 4; k++) neg_ff[k] <= neg_ff[k-1];
      end
   end

   // Chunk by chunk partial products, each one narrow multiplier.
   always_comb begin
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_in[i][j] = a_mag_ff[MUL_CHUNK*i +: MUL_CHUNK] * b_mag_ff[MUL_CHUNK*j +: MUL_CHUNK];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) pp_ff <= pp_in;
   end

   // Row sums: the partials of one chunk of a.
   always_comb begin
      for (int i = 0; i < NA; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < NB; j++) begin
            row_in[i] = row_in[i] + (RWD'(pp_ff[i][j]) << (MUL_CHUNK * j));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) row_ff <= row_in;
   end

   // Final sum of the shifted rows.
   always_comb begin
      mag_in = '0;
      for (int i = 0; i < NA; i++) begin
         mag_in = mag_in + (SPW'(row_ff[i]) << (MUL_CHUNK * i));
      end
   end

   always_ff @(posedge clock) begin
      if (en) mag_ff <= mag_in;
   end

   // Restore the sign.
   assign mag_pw = mag_ff[PW-1:0];

   always_ff @(posedge clock) begin
      if (en) p_ff <= neg_ff[3] ? $signed(~mag_pw + 1'b1) : $signed(mag_pw);
   end

   assign p = p_ff;

endmodule

/* rtl/core/line3d_distance_tester_core.sv */
// Top level of the 3D point and line distance tester against a reference line.
//
//   Port group   Direction  Beat contents
//   req_*        in         tdata: query_a x,y,z then query_b x,y,z; tuser: req_type
//   rsp_*        out        tdata: distance; tuser: within, parallel, status
//   csr_*        in         register index and write data, one write per beat
//
// One beat is accepted in every cycle while req_tready is high; most of the
// pipeline is the quotient and square root digit stages.
// Reset is synchronous; it clears all valid bits and loads the register defaults.
// All stages advance together while the skid register is empty; a held result
// fills the skid register and only then does req_tready fall.
module line3d_distance_tester_core import l3d_pkg::*; #(
   parameter  int COORD_WIDTH = COORD_WIDTH_DEF,
   localparam int REQ_DW      = ((6 * COORD_WIDTH + 7) / 8) * 8,
   localparam int RSP_DW      = ((COORD_WIDTH + 1 + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [2:0]             csr_addr,
   input  logic [COORD_WIDTH:0]   csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DW-1:0]      req_tdata,  // query_a_x, query_a_y, query_a_z,
                                              // query_b_x, query_b_y, query_b_z
   input  logic [0:0]             req_tuser,  // req_type
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DW-1:0]      rsp_tdata,  // distance
   output logic [3:0]             rsp_tuser   // within_tolerance, parallel_fallback,
                                              // status (2 bits)
);

   localparam int CW  = COORD_WIDTH;
   localparam int DW  = CW + 1;
   localparam int PRW = 2 * DW;
   localparam int CRW = PRW + 1;
   localparam int NVW = CRW + DW;
   localparam int SW  = NVW + 2;
   localparam int XW  = 2 * SW;
   localparam int YW  = 2 * CRW + 2;
   localparam int DDW = PRW + 2;
   localparam int QW  = 2 * CW + 2;
   localparam int RW  = CW + 1;

   logic en;

   // Configuration registers.
   logic signed [CW-1:0] pa_ff [3];
   logic signed [CW-1:0] pb_ff [3];
   logic [CW:0]          tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pa_ff[0] <= '0;
         pa_ff[1] <= '0;
         pa_ff[2] <= '0;
         pb_ff[0] <= CW'(64'd1 << FRAC_BITS);
         pb_ff[1] <= '0;
         pb_ff[2] <= '0;
         tol_ff   <= (CW+1)'(TOL_RESET);
      end else if (csr_we) begin
         case (csr_addr)
            REG_A_X: pa_ff[0] <= csr_wdata[CW-1:0];
            REG_A_Y: pa_ff[1] <= csr_wdata[CW-1:0];
            REG_A_Z: pa_ff[2] <= csr_wdata[CW-1:0];
            REG_B_X: pb_ff[0] <= csr_wdata[CW-1:0];
            REG_B_Y: pb_ff[1] <= csr_wdata[CW-1:0];
            REG_B_Z: pb_ff[2] <= csr_wdata[CW-1:0];
            REG_TOL: tol_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Stage 1: direction vectors and the query offset from A.
   logic signed [CW-1:0] qa [3];
   logic signed [CW-1:0] qb [3];
   logic signed [DW-1:0] d_in [3];
   logic signed [DW-1:0] v_in [3];
   logic signed [DW-1:0] e_in [3];
   logic signed [DW-1:0] d_ff [3];
   logic signed [DW-1:0] v_ff [3];
   logic signed [DW-1:0] e_ff [3];
   fmeta_type            s1_meta_in;
   fmeta_type            s1_meta_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qa[i]   = $signed(req_tdata[CW*i +: CW]);
         qb[i]   = $signed(req_tdata[CW*(3+i) +: CW]);
         d_in[i] = DW'(pb_ff[i]) - DW'(pa_ff[i]);
         v_in[i] = DW'(qa[i]) - DW'(pa_ff[i]);
         e_in[i] = DW'(qb[i]) - DW'(qa[i]);
      end
      s1_meta_in.vld    = req_tvalid;
      s1_meta_in.line   = req_tuser[0];
      s1_meta_in.d_zero = (d_in[0] == '0) && (d_in[1] == '0) && (d_in[2] == '0);
      s1_meta_in.e_zero = (e_in[0] == '0) && (e_in[1] == '0) && (e_in[2] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) s1_meta_ff <= '0;
      else if (en) s1_meta_ff <= s1_meta_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in;
         v_ff <= v_in;
         e_ff <= e_in;
      end
   end

   // First multiplier bank: cross product terms and squares of d.
   logic signed [PRW-1:0] pc1 [3];
   logic signed [PRW-1:0] pc2 [3];
   logic signed [PRW-1:0] pn1 [3];
   logic signed [PRW-1:0] pn2 [3];
   logic signed [PRW-1:0] pdd [3];

   for (genvar i = 0; i < 3; i++) begin : g_m1
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;
      l3d_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_c1 (
         .clock, .en, .a(d_ff[J]), .b(v_ff[K]), .p(pc1[i]));
      l3d_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_c2 (
         .clock, .en, .a(d_ff[K]), .b(v_ff[J]), .p(pc2[i]));
      l3d_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_n1 (
         .clock, .en, .a(d_ff[J]), .b(e_ff[K]), .p(pn1[i]));
      l3d_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_n2 (
         .clock, .en, .a(d_ff[K]), .b(e_ff[J]), .p(pn2[i]));
      l3d_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_dd (
         .clock, .en, .a(d_ff[i]), .b(d_ff[i]), .p(pdd[i]));
   end

   fmeta_type            m1_meta_ff [MUL_LAT];
   logic signed [DW-1:0] m1_v_ff [MUL_LAT][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MUL_LAT; k++) m1_meta_ff[k] <= '0;
      end else if (en) begin
         m1_meta_ff[0] <= s1_meta_ff;
         for (int k = 1; k < MUL_LAT; k++) m1_meta_ff[k] <= m1_meta_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_v_ff[0] <= v_ff;
         for (int k = 1; k < MUL_LAT; k++) m1_v_ff[k] <= m1_v_ff[k-1];
      end
   end

   // Stage 2: cross products c = d x v and n = d x e, and |d|^2.
   logic signed [CRW-1:0] c_ff [3];
   logic signed [CRW-1:0] n_ff [3];
   logic signed [DW-1:0]  v2_ff [3];
   logic [DDW-1:0]        dd_ff;
   fmeta_type             s2_meta_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_meta_ff <= '0;
      else if (en) s2_meta_ff <= m1_meta_ff[MUL_LAT-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            c_ff[i] <= CRW'(pc1[i]) - CRW'(pc2[i]);
            n_ff[i] <= CRW'(pn1[i]) - CRW'(pn2[i]);
         end
         v2_ff <= m1_v_ff[MUL_LAT-1];
         dd_ff <= DDW'($unsigned(pdd[0])) + DDW'($unsigned(pdd[1]))
                + DDW'($unsigned(pdd[2]));
      end
   end

   // Second multiplier bank: squares of c and n, and n . v terms.
   logic signed [2*CRW-1:0] pcc [3];
   logic signed [2*CRW-1:0] pnn [3];
   logic signed [NVW-1:0]   pnv [3];

   for (genvar i = 0; i < 3; i++) begin : g_m2
      l3d_mul #(.A_WIDTH(CRW), .B_WIDTH(CRW)) u_cc (
         .clock, .en, .a(c_ff[i]), .b(c_ff[i]), .p(pcc[i]));
      l3d_mul #(.A_WIDTH(CRW), .B_WIDTH(CRW)) u_nn (
         .clock, .en, .a(n_ff[i]), .b(n_ff[i]), .p(pnn[i]));
      l3d_mul #(.A_WIDTH(CRW), .B_WIDTH(DW)) u_nv (
         .clock, .en, .a(n_ff[i]), .b(v2_ff[i]), .p(pnv[i]));
   end

   fmeta_type      m2_meta_ff [MUL_LAT];
   logic [DDW-1:0] m2_dd_ff [MUL_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MUL_LAT; k++) m2_meta_ff[k] <= '0;
      end else if (en) begin
         m2_meta_ff[0] <= s2_meta_ff;
         for (int k = 1; k < MUL_LAT; k++) m2_meta_ff[k] <= m2_meta_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m2_dd_ff[0] <= dd_ff;
         for (int k = 1; k < MUL_LAT; k++) m2_dd_ff[k] <= m2_dd_ff[k-1];
      end
   end

   // Stage 3: |c|^2, |n|^2 and the dot product s = n . v.
   logic [YW-1:0]        cc_ff;
   logic [YW-1:0]        nn_ff;
   logic signed [SW-1:0] s_ff;
   logic [DDW-1:0]       dd3_ff;
   fmeta_type            s3_meta_ff;

   always_ff @(posedge clock) begin
      if (reset) s3_meta_ff <= '0;
      else if (en) s3_meta_ff <= m2_meta_ff[MUL_LAT-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cc_ff  <= YW'($unsigned(pcc[0])) + YW'($unsigned(pcc[1])) + YW'($unsigned(pcc[2]));
         nn_ff  <= YW'($unsigned(pnn[0])) + YW'($unsigned(pnn[1])) + YW'($unsigned(pnn[2]));
         s_ff   <= SW'(pnv[0]) + SW'(pnv[1]) + SW'(pnv[2]);
         dd3_ff <= m2_dd_ff[MUL_LAT-1];
      end
   end

   // Third multiplier: square of the dot product.
   logic signed [XW-1:0] pss;

   l3d_mul #(.A_WIDTH(SW), .B_WIDTH(SW)) u_ss (
      .clock, .en, .a(s_ff), .b(s_ff), .p(pss));

   fmeta_type      m3_meta_ff [MUL_LAT];
   logic [YW-1:0]  m3_cc_ff [MUL_LAT];
   logic [YW-1:0]  m3_nn_ff [MUL_LAT];
   logic [DDW-1:0] m3_dd_ff [MUL_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MUL_LAT; k++) m3_meta_ff[k] <= '0;
      end else if (en) begin
         m3_meta_ff[0] <= s3_meta_ff;
         for (int k = 1; k < MUL_LAT; k++) m3_meta_ff[k] <= m3_meta_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m3_cc_ff[0] <= cc_ff;
         m3_nn_ff[0] <= nn_ff;
         m3_dd_ff[0] <= dd3_ff;
         for (int k = 1; k < MUL_LAT; k++) begin
            m3_cc_ff[k] <= m3_cc_ff[k-1];
            m3_nn_ff[k] <= m3_nn_ff[k-1];
            m3_dd_ff[k] <= m3_dd_ff[k-1];
         end
      end
   end

   // Stage 4: classify the query and pick the numerator and denominator.
   fmeta_type     m3_last;
   bmeta_type     s4_meta_in;
   bmeta_type     s4_meta_ff;
   logic          use_point;
   logic [XW-1:0] x_in;
   logic [YW-1:0] y_in;
   logic [XW-1:0] s4_x_ff;
   logic [YW-1:0] s4_y_ff;

   always_comb begin
      m3_last           = m3_meta_ff[MUL_LAT-1];
      s4_meta_in.vld    = m3_last.vld;
      s4_meta_in.status = ST_OK;
      if (m3_last.d_zero) begin
         s4_meta_in.status = ST_REF_DEGEN;
      end else if (m3_last.line && m3_last.e_zero) begin
         s4_meta_in.status = ST_QRY_DEGEN;
      end
      s4_meta_in.par = (s4_meta_in.status == ST_OK) && m3_last.line
                     && (m3_nn_ff[MUL_LAT-1] == '0);
      use_point = !m3_last.line || s4_meta_in.par;
      if (use_point) begin
         x_in = XW'(m3_cc_ff[MUL_LAT-1]);
         y_in = YW'(m3_dd_ff[MUL_LAT-1]);
      end else begin
         x_in = $unsigned(pss);
         y_in = m3_nn_ff[MUL_LAT-1];
      end
      // A failed query divides zero by one, which yields a zero distance.
      if ((s4_meta_in.status != ST_OK) || (y_in == '0)) begin
         x_in = '0;
         y_in = YW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s4_meta_ff <= '0;
      else if (en) s4_meta_ff <= s4_meta_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_x_ff <= x_in;
         s4_y_ff <= y_in;
      end
   end

   // Restoring division, one quotient bit per stage.
   logic [YW-1:0] dv_rem_ff [QW];
   logic [YW-1:0] dv_y_ff [QW];
   logic [QW-1:0] dv_x_ff [QW];
   logic [QW-1:0] dv_q_ff [QW];
   bmeta_type     dv_meta_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_div
      logic [YW-1:0] rem_p;
      logic [YW-1:0] y_p;
      logic [QW-1:0] x_p;
      logic [QW-1:0] q_p;
      bmeta_type     meta_p;
      logic [YW:0]   trial;
      logic          take;

      if (k == 0) begin : g_first
         assign rem_p  = s4_x_ff[QW +: YW];
         assign x_p    = s4_x_ff[QW-1:0];
         assign q_p    = '0;
         assign y_p    = s4_y_ff;
         assign meta_p = s4_meta_ff;
      end else begin : g_next
         assign rem_p  = dv_rem_ff[k-1];
         assign x_p    = dv_x_ff[k-1];
         assign q_p    = dv_q_ff[k-1];
         assign y_p    = dv_y_ff[k-1];
         assign meta_p = dv_meta_ff[k-1];
      end

      assign trial = {rem_p, x_p[QW-1]};
      assign take  = trial >= {1'b0, y_p};

      always_ff @(posedge clock) begin
         if (reset) dv_meta_ff[k] <= '0;
         else if (en) dv_meta_ff[k] <= meta_p;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_rem_ff[k] <= take ? YW'(trial - {1'b0, y_p}) : trial[YW-1:0];
            dv_x_ff[k]   <= {x_p[QW-2:0], 1'b0};
            dv_q_ff[k]   <= {q_p[QW-2:0], take};
            dv_y_ff[k]   <= y_p;
         end
      end
   end

   // Integer square root, one root bit per stage.
   logic [QW-1:0] sq_rem_ff [RW];
   logic [RW-1:0] sq_root_ff [RW];
   bmeta_type     sq_meta_ff [RW];

   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      localparam int B = RW - 1 - k;
      logic [QW-1:0] rem_p;
      logic [RW-1:0] root_p;
      bmeta_type     meta_p;
      logic [QW:0]   tt;
      logic          take;

      if (k == 0) begin : g_first
         assign rem_p  = dv_q_ff[QW-1];
         assign root_p = '0;
         assign meta_p = dv_meta_ff[QW-1];
      end else begin : g_next
         assign rem_p  = sq_rem_ff[k-1];
         assign root_p = sq_root_ff[k-1];
         assign meta_p = sq_meta_ff[k-1];
      end

      // Trial term (2*root + 2^B) * 2^B against the remaining radicand.
      assign tt   = ((QW+1)'(root_p) << (B + 1)) | ((QW+1)'(1) << (2 * B));
      assign take = {1'b0, rem_p} >= tt;

      always_ff @(posedge clock) begin
         if (reset) sq_meta_ff[k] <= '0;
         else if (en) sq_meta_ff[k] <= meta_p;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_rem_ff[k]  <= take ? QW'({1'b0, rem_p} - tt) : rem_p;
            sq_root_ff[k] <= take ? (root_p | (RW'(1) << B)) : root_p;
         end
      end
   end

   // Final stage: tolerance check.
   bmeta_type     sq_last;
   logic          f_vld_ff;
   logic [RW-1:0] f_dist_ff;
   rflag_type     f_flag_in;
   rflag_type     f_flag_ff;

   always_comb begin
      sq_last          = sq_meta_ff[RW-1];
      f_flag_in.status = sq_last.status;
      f_flag_in.par    = sq_last.par;
      f_flag_in.in_tol = (sq_last.status == ST_OK) && (sq_root_ff[RW-1] <= tol_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) f_vld_ff <= 1'b0;
      else if (en) f_vld_ff <= sq_last.vld;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_dist_ff <= sq_root_ff[RW-1];
         f_flag_ff <= f_flag_in;
      end
   end

   // Output register with a skid register behind it.
   logic          rsp_vld_ff;
   logic [RW-1:0] rsp_dist_ff;
   rflag_type     rsp_flag_ff;
   logic          skid_vld_ff;
   logic [RW-1:0] skid_dist_ff;
   rflag_type     skid_flag_ff;
   logic          leave;
   logic          out_load;

   assign en       = !skid_vld_ff;
   assign leave    = f_vld_ff && en;
   assign out_load = !rsp_vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (out_load) begin
         rsp_vld_ff  <= skid_vld_ff || leave;
         skid_vld_ff <= 1'b0;
      end else if (leave) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_dist_ff <= skid_vld_ff ? skid_dist_ff : f_dist_ff;
         rsp_flag_ff <= skid_vld_ff ? skid_flag_ff : f_flag_ff;
      end else if (leave) begin
         skid_dist_ff <= f_dist_ff;
         skid_flag_ff <= f_flag_ff;
      end
   end

   assign req_tready = en;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = RSP_DW'(rsp_dist_ff);
   assign rsp_tuser  = rsp_flag_ff;

   // A beat parked in the skid register always has one ahead of it.
   assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_vld_ff)
      else $error("skid register holds a beat while the output register is empty");

   // The skid register only fills when the output beat was held back.
   assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(rsp_vld_ff && !rsp_tready))
      else $error("skid register filled without a stalled output");

   // A failed query carries a zero distance and neither the tolerance nor the parallel flag.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && (rsp_flag_ff.status != ST_OK)) |->
         ((rsp_dist_ff == '0) && !rsp_flag_ff.in_tol && !rsp_flag_ff.par))
      else $error("error status with non-zero result fields");

   // Within tolerance means a sound query whose distance is not above the limit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_flag_ff.in_tol) |->
         ((rsp_flag_ff.status == ST_OK) && (rsp_dist_ff <= tol_ff)))
      else $error("tolerance flag disagrees with distance and tolerance");

endmodule

/* verif/line3d_distance_checker.sv */
// Checker for the 3D line distance tester: predicts each result and compares it.
module line3d_distance_checker import l3d_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [32:0]  csr_wdata,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [191:0] req_tdata,
   input  logic [0:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [39:0]  rsp_tdata,
   input  logic [3:0]   rsp_tuser,
   output int           fail_count,
   output int           pending
);

   typedef logic signed [255:0] wide_type;

   typedef struct {
      logic [32:0] distance;
      logic        in_tol;
      logic        par;
      logic [1:0]  status;
   } dist_result_type;

   localparam logic [32:0] DIST_MAX = {33{1'b1}};

   // Shadow copy of the registers: reference points A and B, then the tolerance.
   logic [31:0]     ref_pt[6];
   logic [32:0]     tol_reg;
   dist_result_type expected_q[$];

   function automatic void cross_prod(input wide_type x[3], input wide_type y[3],
                                      output wide_type o[3]);
      for (int i = 0; i < 3; i++)
         o[i] = x[(i + 1) % 3] * y[(i + 2) % 3] - x[(i + 2) % 3] * y[(i + 1) % 3];
   endfunction

   function automatic wide_type sq_norm(input wide_type v[3]);
      return v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
   endfunction

   // Integer square root, rounded down, of a non-negative wide value.
   function automatic logic [63:0] int_sqrt(input wide_type val);
      logic [63:0] root;
      logic [63:0] trial;
      wide_type    tw;
      root = '0;
      for (int bit_i = 62; bit_i >= 0; bit_i--) begin
         trial = root | (64'd1 << bit_i);
         tw = {192'd0, trial};
         if (tw * tw <= val) root = trial;
      end
      return root;
   endfunction

   // Distance of point p from the line through a with direction d.
   function automatic logic [63:0] point_line_dist(input wide_type d[3], input wide_type a[3],
                                                   input wide_type p[3]);
      wide_type v[3];
      wide_type c[3];
      for (int i = 0; i < 3; i++) v[i] = p[i] - a[i];
      cross_prod(d, v, c);
      return int_sqrt(sq_norm(c) / sq_norm(d));
   endfunction

   function automatic dist_result_type predict_distance(input logic line_q,
                                                        input logic [191:0] data);
      wide_type        a[3], q1[3], q2[3], d[3], e[3], n[3];
      wide_type        nn, dot;
      logic [63:0]     dist_val;
      dist_result_type res;
      dist_val = '0;
      res.par = 1'b0;
      res.status = ST_OK;
      for (int i = 0; i < 3; i++) begin
         a[i]  = $signed(ref_pt[i]);
         d[i]  = wide_type'($signed(ref_pt[3 + i])) - a[i];
         q1[i] = $signed(data[32 * i +: 32]);
         q2[i] = $signed(data[32 * (3 + i) +: 32]);
         e[i]  = q2[i] - q1[i];
      end
      if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
         res.status = ST_REF_DEGEN;
      end else if (!line_q) begin
         dist_val = point_line_dist(d, a, q1);
      end else if (e[0] == 0 && e[1] == 0 && e[2] == 0) begin
         res.status = ST_QRY_DEGEN;
      end else begin
         cross_prod(d, e, n);
         nn = sq_norm(n);
         if (nn == 0) begin
            // Parallel lines fall back to the distance of the first query point.
            res.par = 1'b1;
            dist_val = point_line_dist(d, a, q1);
         end else begin
            dot = n[0] * (a[0] - q1[0]) + n[1] * (a[1] - q1[1]) + n[2] * (a[2] - q1[2]);
            dist_val = int_sqrt((dot * dot) / nn);
         end
      end
      res.distance = (dist_val > {31'd0, DIST_MAX}) ? DIST_MAX : dist_val[32:0];
      res.in_tol = (res.status == ST_OK) && (res.distance <= tol_reg);
      return res;
   endfunction

   assign pending = expected_q.size();

   // Track register writes, predict each accepted request and check each result beat.
   always @(posedge clock) begin
      dist_result_type exp_r;
      if (reset) begin
         for (int i = 0; i < 6; i++)
            ref_pt[i] <= (i == int'(REG_B_X)) ? 32'h0001_0000 : 32'h0;
         tol_reg <= 33'(TOL_RESET);
         expected_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_A_X, REG_A_Y, REG_A_Z, REG_B_X, REG_B_Y, REG_B_Z:
                  ref_pt[csr_addr] <= csr_wdata[31:0];
               REG_TOL: tol_reg <= csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_q.push_back(predict_distance(req_tuser[0], req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result beat, distance %h flags %b", $time,
                        rsp_tdata[32:0], rsp_tuser);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_q.pop_front();
               if (rsp_tdata[32:0] !== exp_r.distance || rsp_tuser[0] !== exp_r.in_tol ||
                   rsp_tuser[1] !== exp_r.par || rsp_tuser[3:2] !== exp_r.status) begin
                  $display("%0t: mismatch, expected dist %h in_tol %b par %b status %0d,",
                           $time, exp_r.distance, exp_r.in_tol, exp_r.par, exp_r.status);
                  $display("%0t:   actual dist %h in_tol %b par %b status %0d", $time,
                           rsp_tdata[32:0], rsp_tuser[0], rsp_tuser[1], rsp_tuser[3:2]);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

/* verif/tb_line3d_distance_tester_core.sv */
// Testbench top for the 3D line distance tester: stimulus, flow control and verdict.
module tb_line3d_distance_tester_core import l3d_pkg::*;;

   localparam logic REQ_POINT = 1'b0;
   localparam logic REQ_LINE  = 1'b1;
   localparam int   SETTLE_CYCLES = 140;
   localparam int   PHASE_ITEMS = 273;

   logic         clock = 1'b0;
   logic         reset;
   logic         csr_we;
   logic [2:0]   csr_addr;
   logic [32:0]  csr_wdata;
   logic         req_tvalid;
   logic         req_tready;
   logic [191:0] req_tdata;
   logic [0:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [39:0]  rsp_tdata;
   logic [3:0]   rsp_tuser;
   int           fail_count;
   int           pending;
   int           n_sent = 0;
   logic         calm;

   // Current register settings as written; entry 7 is an unused index.
   logic [32:0]  reg_val[8];

   line3d_distance_tester_core dut (.*);
   line3d_distance_checker chk (.*);

   always #1 clock = ~clock;

   // No idling on either side during a stretch in the middle of the run.
   assign calm = (n_sent >= 900) && (n_sent < 1100);

   // Receiver: random stalls plus one long hold-off that fills the pipeline.
   initial begin
      int hold_left;
      bit held;
      hold_left = 0;
      held = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && n_sent >= 300) begin
            held = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 29);
         end
      end
   end

   // Run limit.
   initial begin
      #2000000;
      $display("line3d_distance_tester_core test failed");
      $finish;
   end

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
         1, 2: return $urandom;
         3: return $urandom_range(32'h0200_0000) - 32'h0100_0000;
         default: begin
            case ($urandom_range(3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'hffff_ffff;
               default: return 32'h0;
            endcase
         end
      endcase
   endfunction

   // Write every register index in one burst; the block must be idle.
   task automatic write_regs();
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_addr <= 3'(i);
         csr_wdata <= (i == int'(REG_TOL)) ? reg_val[i] : {1'b0, reg_val[i][31:0]};
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Wait for every outstanding result plus the pipeline depth.
   task automatic settle();
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_query(input logic kind, input logic [31:0] c[6]);
      if (!calm) begin
         while ($urandom_range(99) < 29) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      for (int i = 0; i < 6; i++) req_tdata[32 * i +: 32] <= c[i];
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n_sent++;
   endtask

   task automatic send_coords(input logic kind, input logic [31:0] ax, ay, az,
                              input logic [31:0] bx, by, bz);
      logic [31:0] c[6];
      c = '{ax, ay, az, bx, by, bz};
      send_query(kind, c);
   endtask

   // Random query: points on and off the line, parallel and degenerate query lines.
   task automatic send_random();
      logic [31:0] c[6];
      int          pick;
      int          k;
      for (int i = 0; i < 6; i++) c[i] = rand_coord();
      pick = $urandom_range(99);
      if (pick < 40) begin
         if ($urandom_range(9) == 0)
            for (int i = 0; i < 3; i++) c[i] = reg_val[3 * $urandom_range(1) + i][31:0];
         send_query(REQ_POINT, c);
      end else begin
         if (pick < 50) begin
            for (int i = 0; i < 3; i++) c[3 + i] = c[i];
         end else if (pick < 70) begin
            k = $urandom_range(6) - 3;
            for (int i = 0; i < 3; i++)
               c[3 + i] = c[i] + 32'(k) * (reg_val[3 + i][31:0] - reg_val[i][31:0]);
         end
         send_query(REQ_LINE, c);
      end
   endtask

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_addr <= '0;
      csr_wdata <= '0;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      reg_val = '{33'd0, 33'd0, 33'd0, 33'h0_0001_0000, 33'd0, 33'd0, 33'(TOL_RESET), 33'd0};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: reference line along the x axis.
      send_coords(REQ_POINT, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      send_coords(REQ_POINT, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                  32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send_coords(REQ_POINT, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                  32'h0, 32'h0, 32'h0);
      send_coords(REQ_POINT, 32'h0005_0000, 32'h0000_0020, 32'h0, 32'h0, 32'h0, 32'h0);
      send_coords(REQ_LINE, 32'h0, 32'h0001_0000, 32'h0, 32'h0005_0000, 32'h0001_0000, 32'h0);
      send_coords(REQ_LINE, 32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff,
                  32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff);
      send_coords(REQ_LINE, 32'h0, 32'h0, 32'h0002_0000, 32'h0, 32'h0001_0000, 32'h0002_0000);
      send_coords(REQ_LINE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_coords(REQ_LINE, 32'h7fff_ffff, 32'h8000_0000, 32'h0,
                  32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
      req_tvalid <= 1'b0;
      settle();

      // Widest reference line with zero tolerance.
      reg_val = '{33'h0_8000_0000, 33'h0_8000_0000, 33'h0_8000_0000,
                  33'h0_7fff_ffff, 33'h0_7fff_ffff, 33'h0_7fff_ffff, 33'd0, 33'h1_ffff_ffff};
      write_regs();
      send_coords(REQ_POINT, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      send_coords(REQ_POINT, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                  32'h0, 32'h0, 32'h0);
      send_coords(REQ_LINE, 32'h8000_0000, 32'h7fff_ffff, 32'h0,
                  32'h7fff_ffff, 32'h8000_0000, 32'h0);
      send_coords(REQ_LINE, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      req_tvalid <= 1'b0;
      settle();

      // Degenerate reference line with the largest tolerance.
      reg_val = '{33'h0_7fff_ffff, 33'h0_8000_0000, 33'h0_1234_5678,
                  33'h0_7fff_ffff, 33'h0_8000_0000, 33'h0_1234_5678, 33'h1_ffff_ffff, 33'd0};
      write_regs();
      send_coords(REQ_POINT, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      send_coords(REQ_LINE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      send_coords(REQ_LINE, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
      req_tvalid <= 1'b0;
      settle();

      // Random phases, each under fresh register settings.
      for (int ph = 0; ph < 6; ph++) begin
         for (int i = 0; i < 3; i++) begin
            reg_val[i] = {1'b0, rand_coord()};
            reg_val[3 + i] = (ph == 5 || $urandom_range(3) == 0) ? {1'b0, rand_coord()} :
                             {1'b0, reg_val[i][31:0] + $urandom_range(32'h0008_0000)};
         end
         if (ph == 4)
            for (int i = 0; i < 3; i++) reg_val[3 + i] = reg_val[i];
         case ($urandom_range(3))
            0: reg_val[REG_TOL] = 33'd0;
            1: reg_val[REG_TOL] = 33'h1_ffff_ffff;
            default: reg_val[REG_TOL] = 33'({$urandom, $urandom}) & 33'h0_00ff_ffff;
         endcase
         reg_val[7] = 33'({$urandom, $urandom});
         write_regs();
         for (int n = 0; n < PHASE_ITEMS; n++) send_random();
         req_tvalid <= 1'b0;
         settle();
      end

      if (fail_count == 0) begin
         $display("line3d_distance_tester_core test passed");
      end else begin
         $display("line3d_distance_tester_core test failed");
      end
      $finish;
   end

endmodule

/* line3d_distance_tester_core.f */
rtl/core/l3d_pkg.sv
rtl/core/l3d_mul.sv
rtl/core/line3d_distance_tester_core.sv
verif/line3d_distance_checker.sv
verif/tb_line3d_distance_tester_core.sv
